@@ src/omw_pkg.sv @@
// Shared types, widths and the heading-to-trig table for the omni wheel mixer.
// No dependencies; every other file imports this package.
package omw_pkg;

  localparam int ANGLE_STEPS    = 360;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;   // signed cos/sin
  localparam int HEAD_W         = 9;
  localparam int MS_W           = 14;
  localparam int PCT_W          = 8;
  localparam int OUT_W          = 15;
  localparam int SRPM_W         = 16;
  localparam int RRPM_W         = 15;
  localparam int RATIO_W        = TRIG_W + 1;
  localparam int MAG_W          = TRIG_W;               // |a|+|b|
  localparam int NM_W           = 34;
  localparam int ABS_W          = 33;
  localparam int DIV_W          = 49;
  localparam int QBITS          = 14;
  localparam int PROD_W         = PCT_W + MS_W + 1;     // signed pct * max speed
  localparam int PMAG_W         = 22;
  // x / 100 == (x * PCT_RECIP) >> PCT_SHIFT for x < 2**PMAG_W
  localparam int PCT_SHIFT      = 29;
  localparam int RECIP_W        = 23;
  localparam logic [RECIP_W-1:0] PCT_RECIP = RECIP_W'(((64'd1 << PCT_SHIFT) + 99) / 100);
  localparam int HEAD_TBL_N     = 360;
  localparam logic [MS_W-1:0] MS_RESET = MS_W'(8000);

  typedef logic [2*TRIG_W-1:0] trig_word_t;
  typedef trig_word_t trig_tbl_t [HEAD_TBL_N];

  typedef struct packed {
    logic signed [TRIG_W-1:0] cs;
    logic signed [TRIG_W-1:0] sn;
    logic signed [SRPM_W-1:0] srpm;
    logic signed [RRPM_W-1:0] rrpm;
  } cmd_t;

  // Elaboration-time trig table, indexed by heading in degrees.
  function automatic trig_tbl_t build_trig();
    trig_tbl_t tbl;
    longint unsigned k, u, quad, rem, t, t2, term;
    longint s30, c30, s, c, lim, cs, sn;
    longint signed sum;
    lim = longint'(1) << TRIG_FRAC_BITS;
    for (int h = 0; h < HEAD_TBL_N; h++) begin
      k    = ((longint'(h) * ANGLE_STEPS * 2 + 360) / 720) % ANGLE_STEPS;
      u    = k * 4;
      quad = u / ANGLE_STEPS;
      rem  = u % ANGLE_STEPS;
      t    = (64'd1686629713 * rem + ANGLE_STEPS / 2) / ANGLE_STEPS;
      t2   = (t * t) >> 30;
      // sin series, divisors n*(n+1) for n = 2, 4 .. 14
      term = t;
      sum  = longint'(t);
      term = ((term * t2) >> 30) / 64'd6;   sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd20;  sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd42;  sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd72;  sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd110; sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd156; sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd210; sum = sum - longint'(term);
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
      s30  = sum;
      // cos series, divisors n*(n+1) for n = 1, 3 .. 13
      term = 64'd1 << 30;
      sum  = longint'(1) << 30;
      term = ((term * t2) >> 30) / 64'd2;   sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd12;  sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd30;  sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd56;  sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd90;  sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd132; sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd182; sum = sum - longint'(term);
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
      c30 = sum;
      s = (s30 + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
      c = (c30 + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
      if (s > lim) s = lim;
      if (c > lim) c = lim;
      case (quad & 3)
        0:       begin sn = s;  cs = c;  end
        1:       begin sn = c;  cs = -s; end
        2:       begin sn = -s; cs = -c; end
        default: begin sn = -c; cs = s;  end
      endcase
      tbl[h] = {TRIG_W'(cs), TRIG_W'(sn)};
    end
    return tbl;
  endfunction

  localparam trig_tbl_t TRIG_TBL = build_trig();

endpackage

@@ src/omw_if.sv @@
// Valid/ready channel interfaces for command and wheel speed words.
// Depends on omw_pkg.
interface omw_in_if;
  import omw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [HEAD_W-1:0]       heading_deg;
  logic signed [PCT_W-1:0] rotation_pct;
  logic signed [PCT_W-1:0] speed_pct;
  modport source (output valid, heading_deg, rotation_pct, speed_pct, input ready);
  modport sink   (input valid, heading_deg, rotation_pct, speed_pct, output ready);
endinterface

interface omw_out_if;
  import omw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] right_speed;
  logic signed [OUT_W-1:0] left_speed;
  logic signed [OUT_W-1:0] back_right_speed;
  logic signed [OUT_W-1:0] back_left_speed;
  modport source (output valid, right_speed, left_speed, back_right_speed, back_left_speed,
                  input ready);
  modport sink   (input valid, right_speed, left_speed, back_right_speed, back_left_speed,
                  output ready);
endinterface

@@ src/omw_front.sv @@
// Front end: heading reduction, trig lookup, percent-to-RPM conversion.
// Depends on omw_pkg.
module omw_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [omw_pkg::HEAD_W-1:0]       in_heading,
  input  logic signed [omw_pkg::PCT_W-1:0] in_rot,
  input  logic signed [omw_pkg::PCT_W-1:0] in_spd,
  input  logic [omw_pkg::MS_W-1:0]         rpm_limit,
  output logic                     push_valid,
  output omw_pkg::cmd_t            push_data
);
  import omw_pkg::*;

  logic                      v1_r, v2_r;
  logic [HEAD_W-1:0]         h_r;
  logic signed [PROD_W-1:0]  ps_r, pr_r;
  logic signed [PROD_W-1:0]  ps_nxt, pr_nxt;
  logic [HEAD_W-1:0]         h_nxt;
  logic [PMAG_W-1:0]         ms_mag, mr_mag;
  logic [PMAG_W+RECIP_W-1:0] qs_r, qr_r;
  logic                      ns_r, nr_r;
  trig_word_t                tw_r;
  logic [SRPM_W-1:0]         smag;
  logic [SRPM_W-1:0]         rmag;
  logic signed [SRPM_W+1:0]  srpm_full, rrpm_full, ms_s;

  always_comb begin
    h_nxt  = (in_heading >= HEAD_W'(360)) ? in_heading - HEAD_W'(360) : in_heading;
    ps_nxt = PROD_W'(in_spd) * PROD_W'($signed({1'b0, rpm_limit}));
    pr_nxt = PROD_W'(in_rot) * PROD_W'($signed({1'b0, rpm_limit}));
    ms_mag = PMAG_W'(ps_r[PROD_W-1] ? -ps_r : ps_r);
    mr_mag = PMAG_W'(pr_r[PROD_W-1] ? -pr_r : pr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r  <= h_nxt;
      ps_r <= ps_nxt;
      pr_r <= pr_nxt;
      tw_r <= TRIG_TBL[h_r];
      qs_r <= ms_mag * PCT_RECIP;
      qr_r <= mr_mag * PCT_RECIP;
      ns_r <= ps_r[PROD_W-1];
      nr_r <= pr_r[PROD_W-1];
    end
  end

  // truncate toward zero, then cap/clamp against the RPM limit
  always_comb begin
    smag      = SRPM_W'(qs_r >> PCT_SHIFT);
    rmag      = SRPM_W'(qr_r >> PCT_SHIFT);
    ms_s      = $signed({4'd0, rpm_limit});
    srpm_full = ns_r ? -$signed({2'b0, smag}) : $signed({2'b0, smag});
    rrpm_full = nr_r ? -$signed({2'b0, rmag}) : $signed({2'b0, rmag});
    if (srpm_full > ms_s) srpm_full = ms_s;
    if (rrpm_full > ms_s) rrpm_full = ms_s;
    if (rrpm_full < -ms_s) rrpm_full = -ms_s;
    push_data.cs   = tw_r[2*TRIG_W-1:TRIG_W];
    push_data.sn   = tw_r[TRIG_W-1:0];
    push_data.srpm = SRPM_W'(srpm_full);
    push_data.rrpm = RRPM_W'(rrpm_full);
    push_valid     = v2_r && en;
  end

endmodule

@@ src/omw_queue.sv @@
// Four-entry word queue between front and back ends.
// Depends on omw_pkg.
module omw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  omw_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop_req,
  output logic          pop_valid,
  output omw_pkg::cmd_t pop_data
);
  import omw_pkg::*;

  cmd_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       pop, wr;

  always_comb begin
    full      = cnt_r == 3'd4;
    pop_valid = cnt_r != 3'd0;
    pop       = pop_req && pop_valid;
    wr        = push && !full;
    pop_data  = mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= push_data;
  end

endmodule

@@ src/omw_div_lane.sv @@
// One bit-per-stage restoring divider lane, rounds half away from zero.
// Depends on omw_pkg.
module omw_div_lane (
  input  logic                           clk,
  input  logic                           en,
  input  logic [omw_pkg::DIV_W-1:0]      num,
  input  logic [omw_pkg::DIV_W-1:0]      den,
  input  logic                           neg,
  output logic signed [omw_pkg::OUT_W-1:0] q
);
  import omw_pkg::*;

  logic [DIV_W-1:0] rem_r [QBITS+1];
  logic [DIV_W-1:0] den_r [QBITS+1];
  logic [QBITS-1:0] q_r   [QBITS+1];
  logic             neg_r [QBITS+1];

  // (2n + d) / (2d)
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DIV_W'({num, 1'b0}) + den;
      den_r[0] <= DIV_W'({den, 1'b0});
      q_r[0]   <= '0;
      neg_r[0] <= neg;
    end
  end

  for (genvar j = 1; j <= QBITS; j++) begin : g_stage
    logic [DIV_W-1:0] trial;
    logic             ge;
    assign trial = den_r[j-1] << (QBITS - j);
    assign ge    = rem_r[j-1] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? rem_r[j-1] - trial : rem_r[j-1];
        den_r[j] <= den_r[j-1];
        q_r[j]   <= q_r[j-1] | (QBITS'(ge) << (QBITS - j));
        neg_r[j] <= neg_r[j-1];
      end
    end
  end

  assign q = neg_r[QBITS] ? -$signed({1'b0, q_r[QBITS]}) : $signed({1'b0, q_r[QBITS]});

endmodule

@@ src/omw_back.sv @@
// Back end: wheel ratios, mix with rotation, normalize and clamp, divide.
// Depends on omw_pkg and omw_div_lane.
module omw_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [omw_pkg::MS_W-1:0] rpm_limit,
  input  logic                     pop_valid,
  input  omw_pkg::cmd_t            pop_data,
  output logic                     pop_req,
  omw_out_if.source                out_ch
);
  import omw_pkg::*;

  localparam int NV = 5 + QBITS;

  logic en;
  logic v_r [NV];

  logic signed [RATIO_W-1:0] r1_r [4];
  logic [MAG_W-1:0]          m1_r, m2_r, m3_r;
  logic signed [SRPM_W-1:0]  s1_r;
  logic signed [RRPM_W-1:0]  rr1_r;
  logic signed [NM_W-1:0]    nm2_r [4];
  logic [ABS_W-1:0]          ab3_r [4];
  logic                      ng3_r [4], ng4_r [4];
  logic [ABS_W-1:0]          big3_r;
  logic [MAG_W+MS_W-1:0]     msm3_r;
  logic [DIV_W-1:0]          num4_r [4];
  logic [DIV_W-1:0]          den4_r;

  logic signed [RATIO_W-1:0] ra [4];
  logic [MAG_W-1:0]          mg;
  logic [ABS_W-1:0]          ab [4];
  logic [ABS_W-1:0]          mx01, mx23, big;
  logic                      sel;
  logic signed [OUT_W-1:0]   q [4];
  logic signed [OUT_W-1:0]   o_r [4];
  logic                      ov_r;

  assign en      = !ov_r || out_ch.ready;
  assign pop_req = en;

  always_comb begin
    logic signed [RATIO_W-1:0] a, b;
    a  = RATIO_W'(pop_data.cs);
    b  = RATIO_W'(pop_data.sn);
    ra[0] = a - b;
    ra[1] = -a - b;
    ra[2] = a + b;
    ra[3] = b - a;
    mg = MAG_W'((a < 0 ? -a : a) + (b < 0 ? -b : b));
    for (int i = 0; i < 4; i++) begin
      ab[i] = ABS_W'(nm2_r[i] < 0 ? -nm2_r[i] : nm2_r[i]);
    end
    mx01 = (ab[0] > ab[1]) ? ab[0] : ab[1];
    mx23 = (ab[2] > ab[3]) ? ab[2] : ab[3];
    big  = (mx01 > mx23) ? mx01 : mx23;
    sel  = ABS_W'(big3_r) > ABS_W'(msm3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NV; i++) v_r[i] <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= pop_valid;
      for (int i = 1; i < NV; i++) v_r[i] <= v_r[i-1];
      ov_r <= v_r[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // zero ratio magnitude: no translation, divide by one
      for (int i = 0; i < 4; i++) r1_r[i] <= (mg == '0) ? '0 : ra[i];
      m1_r  <= (mg == '0) ? MAG_W'(1) : mg;
      s1_r  <= pop_data.srpm;
      rr1_r <= pop_data.rrpm;
      for (int i = 0; i < 4; i++) begin
        nm2_r[i] <= NM_W'(r1_r[i]) * NM_W'(s1_r)
                    - NM_W'(rr1_r) * NM_W'($signed({1'b0, m1_r}));
      end
      m2_r <= m1_r;
      for (int i = 0; i < 4; i++) begin
        ab3_r[i] <= ab[i];
        ng3_r[i] <= nm2_r[i] < 0;
      end
      big3_r <= big;
      msm3_r <= m2_r * rpm_limit;
      m3_r   <= m2_r;
      for (int i = 0; i < 4; i++) begin
        num4_r[i] <= sel ? DIV_W'(ab3_r[i]) * DIV_W'(rpm_limit) : DIV_W'(ab3_r[i]);
        ng4_r[i]  <= ng3_r[i];
      end
      den4_r <= sel ? DIV_W'(big3_r) : DIV_W'(m3_r);
      for (int i = 0; i < 4; i++) o_r[i] <= q[i];
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    omw_div_lane u_div (
      .clk (clk),
      .en  (en),
      .num (num4_r[i]),
      .den (den4_r),
      .neg (ng4_r[i]),
      .q   (q[i])
    );
  end

  assign out_ch.valid            = ov_r;
  assign out_ch.right_speed      = o_r[0];
  assign out_ch.left_speed       = o_r[1];
  assign out_ch.back_right_speed = o_r[2];
  assign out_ch.back_left_speed  = o_r[3];

endmodule

@@ src/omni_wheel_mixer.sv @@
// omni_wheel_mixer: drive command word in, four wheel speed words out.
// Path: 23 register stages from command word to result word: 2 front-end stages, the
// queue write, 4 mix stages, divider load, 14 divider bit stages, output register.
// Throughput: one word per cycle while each output word is taken. Reset (rst_n,
// synchronous) empties all pipes and the queue and sets the RPM limit to 8000;
// data registers are not reset.
module omni_wheel_mixer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [omw_pkg::MS_W-1:0] cfg_wdata,
  omw_in_if.sink                   in_ch,
  omw_out_if.source                out_ch
);
  import omw_pkg::*;

  logic [MS_W-1:0] rpm_limit_r;
  logic            q_full, front_en, push_valid, pop_req, pop_valid;
  cmd_t            push_data, pop_data;

  // config register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpm_limit_r <= MS_RESET;
    end else if (cfg_we) begin
      rpm_limit_r <= cfg_wdata;
    end
  end

  // front end advances whenever the queue has room
  assign front_en    = !q_full;
  assign in_ch.ready = front_en;

  omw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (front_en),
    .in_valid   (in_ch.valid),
    .in_heading (in_ch.heading_deg),
    .in_rot     (in_ch.rotation_pct),
    .in_spd     (in_ch.speed_pct),
    .rpm_limit  (rpm_limit_r),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // decouples the front end from back-end stalls
  omw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .full      (q_full),
    .pop_req   (pop_req),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  // back end stalls as a whole when the output word is not taken
  omw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rpm_limit (rpm_limit_r),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_req   (pop_req),
    .out_ch    (out_ch)
  );

endmodule

@@ src/omw_checker.sv @@
// Port-level assertions for omni_wheel_mixer, attached by bind.
// Depends on omw_pkg.
module omw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [omw_pkg::OUT_W-1:0] out_r,
  input logic signed [omw_pkg::OUT_W-1:0] out_l
);
  import omw_pkg::*;

  localparam logic signed [OUT_W-1:0] MOST_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out word dropped");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_r) && $stable(out_l))
    else $error("out word changed under stall");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid after reset");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_r != MOST_NEG && out_l != MOST_NEG)
    else $error("wheel speed out of range");

endmodule

bind omni_wheel_mixer omw_checker u_omw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_r     (out_ch.right_speed),
  .out_l     (out_ch.left_speed)
);
